// ----- hdl/bgf_pkg.sv -----
package bgf_pkg;

  // Scroll address field masks
  localparam logic [14:0] HORIZ_MASK = 15'h041F;
  localparam logic [14:0] VERT_MASK  = 15'h7BE0;

  // Video memory bases
  localparam logic [13:0] NAME_BASE = 14'h2000;
  localparam logic [13:0] ATTR_BASE = 14'h23C0;

  // Line and dot landmarks
  localparam logic [8:0] LINE_LAST_VISIBLE = 9'd239;
  localparam logic [8:0] LINE_VBLANK       = 9'd241;
  localparam logic [8:0] LINE_PRE          = 9'd261;
  localparam logic [8:0] DOT_FIRST         = 9'd1;
  localparam logic [8:0] DOT_VSTEP         = 9'd256;
  localparam logic [8:0] DOT_HCOPY         = 9'd257;

  // Coarse Y wrap points
  localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
  localparam logic [4:0] COARSE_Y_MAX      = 5'd31;

  // Fetch cycle phases
  localparam logic [2:0] PH_NAME_ISSUE = 3'd0;
  localparam logic [2:0] PH_NAME_LATCH = 3'd1;
  localparam logic [2:0] PH_ATTR_ISSUE = 3'd2;
  localparam logic [2:0] PH_ATTR_LATCH = 3'd3;
  localparam logic [2:0] PH_PLO_ISSUE  = 3'd4;
  localparam logic [2:0] PH_PLO_LATCH  = 3'd5;
  localparam logic [2:0] PH_PHI_ISSUE  = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_BG_RENDER  = 2'd0;
  localparam logic [1:0] REG_PAT_SELECT = 2'd1;
  localparam logic [1:0] REG_VBL_IRQ    = 2'd2;
  localparam logic [1:0] REG_SCROLL_T   = 2'd3;

  typedef struct packed {
    logic        bg_render_on;
    logic        pattern_table_select;
    logic        vbl_irq_on;
    logic [14:0] scroll_temp;
  } bgf_cfg_t;

  typedef struct packed {
    logic [14:0] scroll_v;
    logic [7:0]  name_latch;
    logic [1:0]  attr_latch;
    logic [7:0]  pat_low_latch;
    logic [7:0]  pat_high_latch;
    logic        vblank_state;
  } bgf_state_t;

  typedef struct packed {
    logic [8:0] scan_line;
    logic [8:0] dot_index;
    logic [7:0] read_data;
  } bgf_tick_t;

  typedef struct packed {
    logic        read_enable;
    logic [13:0] read_address;
    logic [7:0]  name_byte;
    logic [1:0]  attr_bits;
    logic [7:0]  pattern_low;
    logic [7:0]  pattern_high;
    logic        tile_done;
    logic        vblank_flag;
    logic        nmi_set;
    logic        clear_flags;
    logic [14:0] scroll_addr;
  } bgf_result_t;

  function automatic logic [7:0] reverse8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7 - i] = b[i];
    return r;
  endfunction

  function automatic logic [13:0] attr_address(input logic [14:0] v);
    return ATTR_BASE | {2'b00, v[11:10], 4'b0000, v[9:7], v[4:2]};
  endfunction

  // Fine Y, then coarse Y with nametable flip at row 29
  function automatic logic [14:0] step_vertical(input logic [14:0] v);
    logic [14:0] r;
    logic [4:0]  y;
    r = v;
    y = v[9:5];
    if (v[14:12] != 3'b111) begin
      r[14:12] = v[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'b000;
      if (y == COARSE_Y_LAST_ROW) begin
        y = 5'd0;
        r[11] = ~v[11];
      end else if (y == COARSE_Y_MAX) begin
        y = 5'd0;
      end else begin
        y = y + 5'd1;
      end
      r[9:5] = y;
    end
    return r;
  endfunction

  // Coarse X with horizontal nametable flip
  function automatic logic [14:0] step_horizontal(input logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v[4:0] == 5'h1F) begin
      r[4:0] = 5'd0;
      r[10]  = ~v[10];
    end else begin
      r[4:0] = v[4:0] + 5'd1;
    end
    return r;
  endfunction

endpackage

// ----- hdl/bgf_tick_logic.sv -----
module bgf_tick_logic import bgf_pkg::*; (
  input  bgf_cfg_t    cfg,
  input  bgf_state_t  state,
  input  bgf_tick_t   tick,
  output bgf_state_t  state_nxt,
  output bgf_result_t result
);

  logic        pre_line;
  logic        render_line;
  logic        fetch_dot;
  logic [2:0]  phase;
  logic [1:0]  attr_sel;
  logic [13:0] pat_addr;
  logic        rd_en;
  logic [13:0] rd_addr;
  logic        done;
  logic        nmi;
  logic        clr;

  assign pre_line    = (tick.scan_line == LINE_PRE);
  assign render_line = pre_line || (tick.scan_line <= LINE_LAST_VISIBLE);
  assign fetch_dot   = (tick.dot_index inside {[9'd1:9'd256], [9'd321:9'd336]});
  assign phase       = tick.dot_index[2:0] - 3'd1;
  assign attr_sel    = {state.scroll_v[6], state.scroll_v[1]};
  assign pat_addr    = {1'b0, cfg.pattern_table_select, state.name_latch, 1'b0,
                        state.scroll_v[14:12]};

  // One dot of the sequencer
  always_comb begin
    state_nxt = state;
    rd_en     = 1'b0;
    rd_addr   = '0;
    done      = 1'b0;
    nmi       = 1'b0;
    clr       = 1'b0;

    // vblank flag
    if (pre_line && tick.dot_index == DOT_FIRST) begin
      state_nxt.vblank_state = 1'b0;
      clr = 1'b1;
    end
    if (tick.scan_line == LINE_VBLANK && tick.dot_index == DOT_FIRST) begin
      state_nxt.vblank_state = 1'b1;
      nmi = cfg.vbl_irq_on;
    end

    // fetch cycle, increments and copies
    if (render_line && cfg.bg_render_on) begin
      if (fetch_dot) begin
        case (phase)
          PH_NAME_ISSUE: begin
            rd_en   = 1'b1;
            rd_addr = NAME_BASE | {2'b00, state.scroll_v[11:0]};
          end
          PH_NAME_LATCH: begin
            state_nxt.name_latch = tick.read_data;
          end
          PH_ATTR_ISSUE: begin
            rd_en   = 1'b1;
            rd_addr = attr_address(state.scroll_v);
          end
          PH_ATTR_LATCH: begin
            case (attr_sel)
              2'd0:    state_nxt.attr_latch = tick.read_data[1:0];
              2'd1:    state_nxt.attr_latch = tick.read_data[3:2];
              2'd2:    state_nxt.attr_latch = tick.read_data[5:4];
              default: state_nxt.attr_latch = tick.read_data[7:6];
            endcase
          end
          PH_PLO_ISSUE: begin
            rd_en   = 1'b1;
            rd_addr = pat_addr;
          end
          PH_PLO_LATCH: begin
            state_nxt.pat_low_latch = reverse8(tick.read_data);
          end
          PH_PHI_ISSUE: begin
            rd_en   = 1'b1;
            rd_addr = pat_addr | 14'h0008;
          end
          default: begin
            state_nxt.pat_high_latch = reverse8(tick.read_data);
            done = 1'b1;
            if (tick.dot_index == DOT_VSTEP) begin
              state_nxt.scroll_v = step_vertical(state.scroll_v);
            end else begin
              state_nxt.scroll_v = step_horizontal(state.scroll_v);
            end
          end
        endcase
      end else if (tick.dot_index == DOT_HCOPY) begin
        state_nxt.scroll_v = (state.scroll_v & ~HORIZ_MASK) | (cfg.scroll_temp & HORIZ_MASK);
      end else if (pre_line && (tick.dot_index inside {[9'd280:9'd304]})) begin
        state_nxt.scroll_v = (state.scroll_v & ~VERT_MASK) | (cfg.scroll_temp & VERT_MASK);
      end
    end
  end

  // Result as seen after this dot
  always_comb begin
    result.read_enable  = rd_en;
    result.read_address = rd_addr;
    result.name_byte    = state_nxt.name_latch;
    result.attr_bits    = state_nxt.attr_latch;
    result.pattern_low  = state_nxt.pat_low_latch;
    result.pattern_high = state_nxt.pat_high_latch;
    result.tile_done    = done;
    result.vblank_flag  = state_nxt.vblank_state;
    result.nmi_set      = nmi;
    result.clear_flags  = clr;
    result.scroll_addr  = state_nxt.scroll_v;
  end

endmodule

// ----- hdl/ppu_background_fetch_sequencer.sv -----
// Channel   Dir  Handshake            Payload
// in_       in   in_valid/in_ready    scan_line, dot_index, read_data
// out_      out  out_valid/out_ready  read fields, tile latches, flags, scroll_addr
// cfg_      in   cfg_valid/cfg_ready  cfg_index (0..3), cfg_data (15 bits)
//
// One dot request per cycle unless the result stalls; each goes via the input
// register, then the result register. State updates as a dot moves into
// the result register. Reset clears config, scroll address, latches and flags.
// A stalled result holds the result register and the input register behind it;
// in_ready falls only when both are full. cfg_ready is always high.
module ppu_background_fetch_sequencer import bgf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [8:0]  in_scan_line,
  input  logic [8:0]  in_dot_index,
  input  logic [7:0]  in_read_data,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_read_enable,
  output logic [13:0] out_read_address,
  output logic [7:0]  out_name_byte,
  output logic [1:0]  out_attr_bits,
  output logic [7:0]  out_pattern_low,
  output logic [7:0]  out_pattern_high,
  output logic        out_tile_done,
  output logic        out_vblank_flag,
  output logic        out_nmi_set,
  output logic        out_clear_flags,
  output logic [14:0] out_scroll_addr,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  bgf_cfg_t    cfg_r;
  bgf_state_t  state_r;
  bgf_state_t  state_nxt;
  bgf_tick_t   tick_r;
  logic        tick_valid_r;
  bgf_result_t result_nxt;
  bgf_result_t result_r;
  logic        out_valid_r;
  logic        advance;

  assign cfg_ready = 1'b1;
  assign advance   = tick_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !tick_valid_r || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BG_RENDER:  cfg_r.bg_render_on         <= cfg_data[0];
        REG_PAT_SELECT: cfg_r.pattern_table_select <= cfg_data[0];
        REG_VBL_IRQ:    cfg_r.vbl_irq_on           <= cfg_data[0];
        REG_SCROLL_T:   cfg_r.scroll_temp          <= cfg_data;
        default:        cfg_r                      <= cfg_r;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
    end else if (in_ready) begin
      tick_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick_r <= '{scan_line: in_scan_line, dot_index: in_dot_index, read_data: in_read_data};
    end
  end

  bgf_tick_logic u_tick (
    .cfg       (cfg_r),
    .state     (state_r),
    .tick      (tick_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_enable  = result_r.read_enable;
  assign out_read_address = result_r.read_address;
  assign out_name_byte    = result_r.name_byte;
  assign out_attr_bits    = result_r.attr_bits;
  assign out_pattern_low  = result_r.pattern_low;
  assign out_pattern_high = result_r.pattern_high;
  assign out_tile_done    = result_r.tile_done;
  assign out_vblank_flag  = result_r.vblank_flag;
  assign out_nmi_set      = result_r.nmi_set;
  assign out_clear_flags  = result_r.clear_flags;
  assign out_scroll_addr  = result_r.scroll_addr;

endmodule

// ----- dv/ppu_background_fetch_sequencer_check.sv -----
module ppu_background_fetch_sequencer_check import bgf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [8:0]  in_scan_line,
  input  logic [8:0]  in_dot_index,
  input  logic [7:0]  in_read_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_read_enable,
  input  logic [13:0] out_read_address,
  input  logic [7:0]  out_name_byte,
  input  logic [1:0]  out_attr_bits,
  input  logic [7:0]  out_pattern_low,
  input  logic [7:0]  out_pattern_high,
  input  logic        out_tile_done,
  input  logic        out_vblank_flag,
  input  logic        out_nmi_set,
  input  logic        out_clear_flags,
  input  logic [14:0] out_scroll_addr,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          checked,
  output int          tiles
);
  timeunit 1ns;
  timeprecision 1ps;

  // Dot landmarks not in the package
  localparam logic [8:0] DOT_VCOPY_FIRST    = 9'd280;
  localparam logic [8:0] DOT_VCOPY_LAST     = 9'd304;
  localparam logic [8:0] DOT_PREFETCH_FIRST = 9'd321;
  localparam logic [8:0] DOT_PREFETCH_LAST  = 9'd336;

  // Shadow configuration
  logic        bg_on;
  logic        pat_sel;
  logic        nmi_on;
  logic [14:0] temp_addr;

  // Shadow fetch state
  logic [14:0] v_addr;
  logic [7:0]  nt_byte;
  logic [1:0]  palette;
  logic [7:0]  plane_lo;
  logic [7:0]  plane_hi;
  logic        in_vblank;

  bgf_result_t expected_dots[$];

  function automatic logic [7:0] mirror_byte(input logic [7:0] b);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) m[i] = b[7 - i];
    return m;
  endfunction

  // One dot tick: updates the shadow state, returns the expected result
  function automatic bgf_result_t advance_dot(input bgf_tick_t t);
    bgf_result_t r;
    logic        pre;
    logic        rend;
    logic [2:0]  ph;
    logic [1:0]  quad;
    logic [13:0] pat_addr;
    logic [8:0]  dot;
    r    = '0;
    dot  = t.dot_index;
    pre  = (t.scan_line == LINE_PRE);
    rend = pre || (t.scan_line <= LINE_LAST_VISIBLE);

    if (pre && dot == DOT_FIRST) begin
      in_vblank     = 1'b0;
      r.clear_flags = 1'b1;
    end
    if (t.scan_line == LINE_VBLANK && dot == DOT_FIRST) begin
      in_vblank = 1'b1;
      r.nmi_set = nmi_on;
    end

    if (rend && bg_on) begin
      if ((dot >= DOT_FIRST && dot <= DOT_VSTEP) ||
          (dot >= DOT_PREFETCH_FIRST && dot <= DOT_PREFETCH_LAST)) begin
        ph       = dot[2:0] - 3'd1;
        pat_addr = {1'b0, pat_sel, nt_byte, 1'b0, v_addr[14:12]};
        case (ph)
          PH_NAME_ISSUE: begin
            r.read_enable  = 1'b1;
            r.read_address = NAME_BASE | {2'b00, v_addr[11:0]};
          end
          PH_NAME_LATCH: nt_byte = t.read_data;
          PH_ATTR_ISSUE: begin
            r.read_enable  = 1'b1;
            r.read_address = {2'b10, v_addr[11:10], 4'b1111, v_addr[9:7], v_addr[4:2]};
          end
          PH_ATTR_LATCH: begin
            quad    = {v_addr[6], v_addr[1]};
            palette = t.read_data[quad * 2 +: 2];
          end
          PH_PLO_ISSUE: begin
            r.read_enable  = 1'b1;
            r.read_address = pat_addr;
          end
          PH_PLO_LATCH: plane_lo = mirror_byte(t.read_data);
          PH_PHI_ISSUE: begin
            r.read_enable  = 1'b1;
            r.read_address = pat_addr | 14'h0008;
          end
          default: begin
            plane_hi    = mirror_byte(t.read_data);
            r.tile_done = 1'b1;
            if (dot == DOT_VSTEP) begin
              // fine Y, then coarse Y with the row 29 nametable flip
              if (v_addr[14:12] != 3'b111) begin
                v_addr[14:12] = v_addr[14:12] + 3'd1;
              end else begin
                v_addr[14:12] = 3'b000;
                if (v_addr[9:5] == COARSE_Y_LAST_ROW) begin
                  v_addr[9:5] = 5'd0;
                  v_addr[11]  = ~v_addr[11];
                end else if (v_addr[9:5] == COARSE_Y_MAX) begin
                  v_addr[9:5] = 5'd0;
                end else begin
                  v_addr[9:5] = v_addr[9:5] + 5'd1;
                end
              end
            end else if (v_addr[4:0] == 5'h1F) begin
              v_addr[4:0] = 5'd0;
              v_addr[10]  = ~v_addr[10];
            end else begin
              v_addr[4:0] = v_addr[4:0] + 5'd1;
            end
          end
        endcase
      end else if (dot == DOT_HCOPY) begin
        v_addr = (v_addr & ~HORIZ_MASK) | (temp_addr & HORIZ_MASK);
      end else if (pre && dot >= DOT_VCOPY_FIRST && dot <= DOT_VCOPY_LAST) begin
        v_addr = (v_addr & ~VERT_MASK) | (temp_addr & VERT_MASK);
      end
    end

    r.name_byte    = nt_byte;
    r.attr_bits    = palette;
    r.pattern_low  = plane_lo;
    r.pattern_high = plane_hi;
    r.vblank_flag  = in_vblank;
    r.scroll_addr  = v_addr;
    return r;
  endfunction

  function automatic string describe(input bgf_result_t r);
    return $sformatf("rd=%0d addr=%h nt=%h at=%0d lo=%h hi=%h done=%0d vb=%0d nmi=%0d clr=%0d v=%h",
                     r.read_enable, r.read_address, r.name_byte, r.attr_bits, r.pattern_low,
                     r.pattern_high, r.tile_done, r.vblank_flag, r.nmi_set, r.clear_flags,
                     r.scroll_addr);
  endfunction

  // Compare results, track config writes, predict accepted requests
  always @(posedge clk) begin
    bgf_result_t got;
    bgf_result_t want;
    if (!rst_n) begin
      bg_on       = 1'b0;
      pat_sel     = 1'b0;
      nmi_on      = 1'b0;
      temp_addr   = '0;
      v_addr      = '0;
      nt_byte     = '0;
      palette     = '0;
      plane_lo    = '0;
      plane_hi    = '0;
      in_vblank   = 1'b0;
      mismatches  = 0;
      checked     = 0;
      tiles       = 0;
      expected_dots.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_read_enable, out_read_address, out_name_byte, out_attr_bits,
               out_pattern_low, out_pattern_high, out_tile_done, out_vblank_flag,
               out_nmi_set, out_clear_flags, out_scroll_addr};
        if (expected_dots.size() == 0) begin
          if (mismatches < 10) $display("result with no request pending: %s", describe(got));
          mismatches++;
        end else begin
          want = expected_dots.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("mismatch on result %0d", checked);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
            mismatches++;
          end
          checked++;
          if (want.tile_done) tiles++;
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BG_RENDER:  bg_on     = cfg_data[0];
          REG_PAT_SELECT: pat_sel   = cfg_data[0];
          REG_VBL_IRQ:    nmi_on    = cfg_data[0];
          REG_SCROLL_T:   temp_addr = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready)
        expected_dots.push_back(advance_dot({in_scan_line, in_dot_index, in_read_data}));
    end
    outstanding = expected_dots.size();
  end

endmodule

// ----- dv/ppu_background_fetch_sequencer_test.sv -----
module ppu_background_fetch_sequencer_test import bgf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT   = 200_000;
  localparam int PHASE_ITEMS = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [8:0]  in_scan_line;
  logic [8:0]  in_dot_index;
  logic [7:0]  in_read_data;
  logic        out_valid;
  logic        out_ready;
  logic        out_read_enable;
  logic [13:0] out_read_address;
  logic [7:0]  out_name_byte;
  logic [1:0]  out_attr_bits;
  logic [7:0]  out_pattern_low;
  logic [7:0]  out_pattern_high;
  logic        out_tile_done;
  logic        out_vblank_flag;
  logic        out_nmi_set;
  logic        out_clear_flags;
  logic [14:0] out_scroll_addr;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  int mismatches;
  int outstanding;
  int checked;
  int tiles;

  int cycle_count = 0;
  int items_sent  = 0;
  int settings    = 0;
  bit send_burst  = 1'b0;
  bit squeeze_req = 1'b0;

  ppu_background_fetch_sequencer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_scan_line     (in_scan_line),
    .in_dot_index     (in_dot_index),
    .in_read_data     (in_read_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_enable  (out_read_enable),
    .out_read_address (out_read_address),
    .out_name_byte    (out_name_byte),
    .out_attr_bits    (out_attr_bits),
    .out_pattern_low  (out_pattern_low),
    .out_pattern_high (out_pattern_high),
    .out_tile_done    (out_tile_done),
    .out_vblank_flag  (out_vblank_flag),
    .out_nmi_set      (out_nmi_set),
    .out_clear_flags  (out_clear_flags),
    .out_scroll_addr  (out_scroll_addr),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  ppu_background_fetch_sequencer_check u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("ppu_background_fetch_sequencer verification failed");
      $finish;
    end
  end

  // All tasks start and end on a falling edge
  task automatic send_dot(input logic [8:0] line, input logic [8:0] dot,
                          input logic [7:0] data);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_scan_line <= line;
    in_dot_index <= dot;
    in_read_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Consecutive dots (some skipped when broken), wrapping into the next line after dot 340
  task automatic run_dots(input logic [8:0] line, input logic [8:0] dot, input int n,
                          input bit broken = 1'b0);
    for (int i = 0; i < n; i++) begin
      send_dot(line, dot, 8'($urandom_range(0, 255)));
      if (broken && $urandom_range(0, 5) == 0) dot = dot + 9'd1;
      if (dot >= 9'd340) begin
        dot  = 9'd0;
        line = (line == LINE_PRE) ? 9'd0 : line + 9'd1;
      end else begin
        dot = dot + 9'd1;
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Single-bit registers get junk above bit 0
  task automatic set_config(input bit bg, input bit pat, input bit nmi,
                            input logic [14:0] t);
    logic [13:0] junk_bg;
    logic [13:0] junk_pat;
    logic [13:0] junk_nmi;
    junk_bg  = 14'($urandom_range(0, 16383));
    junk_pat = 14'($urandom_range(0, 16383));
    junk_nmi = 14'($urandom_range(0, 16383));
    write_reg(REG_BG_RENDER,  {junk_bg, bg});
    write_reg(REG_PAT_SELECT, {junk_pat, pat});
    write_reg(REG_VBL_IRQ,    {junk_nmi, nmi});
    write_reg(REG_SCROLL_T,   t);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Mostly contiguous dot runs near the interesting dots; some noise
  task automatic run_segment(input bit hold_burst);
    logic [8:0] line;
    logic [8:0] dot;
    int         pick;
    send_burst = hold_burst || ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_dot(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                 8'($urandom_range(0, 255)));
    end else begin
      pick = $urandom_range(0, 9);
      if (pick <= 4)      line = ($urandom_range(0, 3) == 0) ? 9'd0 : 9'($urandom_range(0, 239));
      else if (pick <= 6) line = LINE_PRE;
      else if (pick == 7) line = LINE_VBLANK;
      else if (pick == 8) line = 9'($urandom_range(240, 260));
      else                line = 9'($urandom_range(262, 511));
      case ($urandom_range(0, 9))
        0: dot = 9'd0;
        1: dot = DOT_FIRST;
        2: dot = 9'($urandom_range(245, 256));
        3: dot = 9'($urandom_range(275, 300));
        4: dot = 9'($urandom_range(315, 336));
        5: dot = 9'($urandom_range(330, 340));
        default: dot = 9'($urandom_range(0, 340));
      endcase
      run_dots(line, dot, $urandom_range(8, 40), $urandom_range(0, 7) == 0);
    end
  endtask

  // Result side: random stalls, steady stretches, one long hold-off
  initial begin
    int stall;
    bit steady;
    bit squeezed;
    out_ready = 1'b0;
    steady    = 1'b0;
    squeezed  = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        stall    = 80;
        squeezed = 1'b1;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 12);
      end
      if ($urandom_range(0, 29) == 0) steady = !steady;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Request side and verdict
  initial begin
    bit          bg;
    bit          pat;
    bit          nmi;
    logic [14:0] t;
    int          quota;
    in_valid     = 1'b0;
    in_scan_line = '0;
    in_dot_index = '0;
    in_read_data = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_BG_RENDER;
    cfg_data     = '0;
    rst_n        = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Background off: vblank set without NMI, flag clear, no fetch, out-of-range dots
    send_dot(LINE_VBLANK, DOT_FIRST, 8'h00);
    send_dot(LINE_PRE, DOT_FIRST, 8'hFF);
    send_dot(9'd0, DOT_FIRST, 8'hFF);
    send_dot(9'd511, 9'd511, 8'hFF);
    send_dot(9'd0, 9'd0, 8'h00);
    wait_idle();

    // t: fine Y 7, coarse Y 29, coarse X 31, both nametable bits
    set_config(1'b1, 1'b1, 1'b1, 15'h7FBF);
    send_dot(LINE_PRE, 9'd280, 8'h5A);
    send_dot(LINE_PRE, DOT_HCOPY, 8'hA5);
    send_dot(LINE_VBLANK, DOT_FIRST, 8'h00);
    // full tile ending in the vertical step, then one ending in coarse X wrap
    run_dots(9'd0, 9'd249, 8);
    run_dots(9'd0, 9'd321, 8);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin bg = 1'b1; pat = 1'b1; nmi = 1'b1; t = 15'h7FFF; end
        1: begin bg = 1'b1; pat = 1'b0; nmi = 1'b0; t = 15'h0000; end
        2: begin
          bg  = 1'b0;
          pat = 1'($urandom_range(0, 1));
          nmi = 1'b1;
          t   = 15'($urandom_range(0, 32767));
        end
        3: begin
          // coarse Y 31 with fine Y 7 wraps without a nametable flip
          bg  = 1'b1;
          pat = 1'($urandom_range(0, 1));
          nmi = 1'($urandom_range(0, 1));
          t   = 15'h73E0 | (15'($urandom_range(0, 32767)) & 15'h0C1F);
        end
        default: begin
          bg  = ($urandom_range(0, 3) != 0);
          pat = 1'($urandom_range(0, 1));
          nmi = 1'($urandom_range(0, 1));
          t   = 15'($urandom_range(0, 32767));
        end
      endcase
      set_config(bg, pat, nmi, t);
      quota = items_sent + PHASE_ITEMS;
      if (p == 3) begin
        send_burst  = 1'b1;
        squeeze_req = 1'b1;
        run_dots(LINE_PRE, 9'd300, 5);
        run_dots(9'd0, 9'd249, 8);
      end
      while (items_sent < quota) run_segment(p == 3);
      wait_idle();
    end

    repeat (4) @(negedge clk);
    $display("dots checked: %0d, tiles fetched: %0d, register settings: %0d",
             checked, tiles, settings);
    $display("mismatches: %0d, results still due: %0d", mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ppu_background_fetch_sequencer verification clean");
    end else begin
      $display("ppu_background_fetch_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bgf_pkg.sv
hdl/bgf_tick_logic.sv
hdl/ppu_background_fetch_sequencer.sv
dv/ppu_background_fetch_sequencer_check.sv
dv/ppu_background_fetch_sequencer_test.sv
